// ----- design/tlfb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfb_pkg
// Shared types and constants of the temporal luma frame blend unit.
// ----------------------------------------------------------------------------
package tlfb_pkg;

  localparam int unsigned FRAME_PIXELS_DEF = 16384;
  localparam int unsigned PLANE_COUNT_DEF  = 32;

  localparam int unsigned LUMA_W    = 8;
  localparam int unsigned HIST_W    = 6;
  localparam int unsigned STRIDE_W  = 4;
  localparam int unsigned TAP_COUNT = 4;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 4'd8;

  typedef struct packed {
    logic [LUMA_W-1:0] luma_in;
    logic              frame_end_in;
  } pix_in_t;

  typedef struct packed {
    logic [LUMA_W-1:0] luma_out;
    logic              frame_end_out;
  } pix_out_t;

endpackage

// ----- design/temporal_luma_frame_blend_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temporal_luma_frame_blend_unit
// Four-tap temporal blend of a luma stream over a plane history store.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word is registered in stage 1 (row read, merge), then
//   stage 2 (tap select), stage 3 (sum, write-back) and the output register.
// Throughput: one word per cycle while the output side takes words. A word
//   whose pixel position equals that of one of the two words still ahead of
//   the merge point waits; this only arises with frames of one or two pixels.
// Reset: pixel position and current plane go to zero, the stride to eight.
//   The history store is not swept; a fill count makes unwritten rows read
//   as zero, so the block accepts words right after reset.
// ----------------------------------------------------------------------------
module temporal_luma_frame_blend_unit #(
  parameter int unsigned FRAME_PIXELS = tlfb_pkg::FRAME_PIXELS_DEF,
  parameter int unsigned PLANE_COUNT  = tlfb_pkg::PLANE_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tlfb_pkg::pix_in_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tlfb_pkg::pix_out_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [tlfb_pkg::STRIDE_W-1:0]   cfg_wdata_i
);

  import tlfb_pkg::*;

  // The store is organized as one row per pixel position, holding that
  // pixel's entry of every plane. Each word then costs one row read and one
  // row write, and a row that has never been written is recognized by its
  // position alone: positions are visited from zero upward, so the rows
  // written so far always form a prefix whose length is the fill count.
  localparam int unsigned POS_W  = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int unsigned FILL_W = $clog2(FRAME_PIXELS + 1);
  localparam int unsigned CUR_W  = $clog2(PLANE_COUNT);
  localparam int unsigned TAP_W  = CUR_W + 1;
  localparam int unsigned ROW_W  = PLANE_COUNT * HIST_W;

  typedef logic [PLANE_COUNT-1:0][HIST_W-1:0] row_t;
  typedef logic [TAP_COUNT-1:0][CUR_W-1:0]    tap_idx_t;
  typedef logic [TAP_COUNT-1:0][HIST_W-1:0]   tap_val_t;

  // --------------------------------------------------------------------------
  // Configuration register and frame counters
  // --------------------------------------------------------------------------
  logic [STRIDE_W-1:0] stride_q;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [CUR_W-1:0]    cur_q, cur_d;
  logic [FILL_W-1:0]   fill_q, fill_d;

  logic adv;     // whole pipeline moves one step
  logic hazard;  // incoming position still being updated ahead
  logic acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= STRIDE_RESET;
    end else if (cfg_we_i) begin
      stride_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    cur_d  = cur_q;
    fill_d = fill_q;
    if (acc) begin
      if (FILL_W'(pos_q) == fill_q) begin
        fill_d = fill_q + FILL_W'(1);
      end
      if (in_data_i.frame_end_in) begin
        pos_d = '0;
        cur_d = (cur_q == CUR_W'(PLANE_COUNT - 1)) ? '0 : cur_q + CUR_W'(1);
      end else begin
        pos_d = (pos_q == POS_W'(FRAME_PIXELS - 1)) ? '0 : pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      cur_q  <= '0;
      fill_q <= '0;
    end else begin
      pos_q  <= pos_d;
      cur_q  <= cur_d;
      fill_q <= fill_d;
    end
  end

  // Tap planes: base = current plane AND (stride - 1) in four bits, then
  // base + k * stride folded back into the plane range. The raw value stays
  // below 64, which is under twice the default plane count of 32, so one
  // compare and subtract suffices.
  logic [STRIDE_W-1:0] mask;
  logic [TAP_W-1:0]    base;
  logic [TAP_W-1:0]    tap_raw [TAP_COUNT];
  tap_idx_t            tap_idx;

  always_comb begin
    mask = stride_q - STRIDE_W'(1);
    base = TAP_W'(cur_q[STRIDE_W-1:0] & mask);
    for (int k = 0; k < TAP_COUNT; k++) begin
      tap_raw[k] = base + TAP_W'(k) * TAP_W'(stride_q);
      if (tap_raw[k] >= TAP_W'(PLANE_COUNT)) begin
        tap_idx[k] = CUR_W'(tap_raw[k] - TAP_W'(PLANE_COUNT));
      end else begin
        tap_idx[k] = CUR_W'(tap_raw[k]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. All stages advance together whenever the output register can
  // take a word; a bubble is inserted while the incoming position collides
  // with one of the two words whose write-back row is not yet known.
  // --------------------------------------------------------------------------
  logic             s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  logic [POS_W-1:0] s1_pos_q, s2_pos_q, s3_pos_q;

  assign adv    = !out_vld_q || out_ready_i;
  assign hazard = (s1_vld_q && (s1_pos_q == pos_q)) ||
                  (s2_vld_q && (s2_pos_q == pos_q));
  assign in_ready_o = adv && !hazard;
  assign acc        = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // History row memory
  // --------------------------------------------------------------------------
  logic             ram_we;
  row_t             ram_wdata;
  logic [ROW_W-1:0] ram_rdata;

  tlfb_row_ram #(
    .DEPTH  (FRAME_PIXELS),
    .ADDR_W (POS_W),
    .DATA_W (ROW_W)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s3_pos_q),
    .wdata_i (ram_wdata),
    .re_i    (acc),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 1: row read returns. The row written at the same edge as this read
  // is held in the forward register and takes priority over the memory.
  // The new pixel's entry replaces the current plane before any tap is read.
  // --------------------------------------------------------------------------
  logic              s1_fend_q, s1_hit_q;
  logic [CUR_W-1:0]  s1_cur_q;
  logic [HIST_W-1:0] s1_luma_q;
  tap_idx_t          s1_tap_q;

  logic              fwd_vld_q;
  logic [POS_W-1:0]  fwd_pos_q;
  row_t              fwd_row_q;

  row_t s1_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pos_q  <= pos_q;
      s1_cur_q  <= cur_q;
      s1_tap_q  <= tap_idx;
      s1_luma_q <= in_data_i.luma_in[LUMA_W-1 -: HIST_W];
      s1_fend_q <= in_data_i.frame_end_in;
      s1_hit_q  <= FILL_W'(pos_q) < fill_q;
    end
  end

  always_comb begin
    if (fwd_vld_q && (fwd_pos_q == s1_pos_q)) begin
      s1_row = fwd_row_q;
    end else if (s1_hit_q) begin
      s1_row = row_t'(ram_rdata);
    end else begin
      s1_row = '0;
    end
    s1_row[s1_cur_q] = s1_luma_q;
  end

  // --------------------------------------------------------------------------
  // Stage 2: select the four tap entries from the merged row.
  // --------------------------------------------------------------------------
  logic             s2_fend_q;
  logic [CUR_W-1:0] s2_cur_q;
  tap_idx_t         s2_tap_q;
  row_t             s2_row_q;
  tap_val_t         s2_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_pos_q  <= s1_pos_q;
      s2_cur_q  <= s1_cur_q;
      s2_tap_q  <= s1_tap_q;
      s2_fend_q <= s1_fend_q;
      s2_row_q  <= s1_row;
    end
  end

  always_comb begin
    for (int k = 0; k < TAP_COUNT; k++) begin
      s2_val[k] = s2_row_q[s2_tap_q[k]];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum the taps, store sum / 4 in the current plane and write the
  // row back. The sum of four 6-bit entries is at most 252.
  // --------------------------------------------------------------------------
  logic              s3_fend_q;
  logic [CUR_W-1:0]  s3_cur_q;
  row_t              s3_row_q;
  tap_val_t          s3_val_q;
  logic [LUMA_W-1:0] s3_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_pos_q  <= s2_pos_q;
      s3_cur_q  <= s2_cur_q;
      s3_fend_q <= s2_fend_q;
      s3_row_q  <= s2_row_q;
      s3_val_q  <= s2_val;
    end
  end

  always_comb begin
    s3_sum = '0;
    for (int k = 0; k < TAP_COUNT; k++) begin
      s3_sum = s3_sum + LUMA_W'(s3_val_q[k]);
    end
    ram_wdata = s3_row_q;
    ram_wdata[s3_cur_q] = s3_sum[LUMA_W-1 -: HIST_W];
  end

  assign ram_we = adv && s3_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (adv) begin
      fwd_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fwd_pos_q <= s3_pos_q;
      fwd_row_q <= ram_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  pix_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.luma_out      <= s3_sum;
      out_q.frame_end_out <= s3_fend_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Two words whose write-back rows are still open never share a position.
  a_no_open_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s2_vld_q) |-> (s1_pos_q != s2_pos_q))
    else $error("two in-flight words share a pixel position");

  // The fill count never runs past the frame and covers the next position.
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q <= FILL_W'(FRAME_PIXELS)) && (FILL_W'(pos_q) <= fill_q))
    else $error("fill count out of range");

  // A frame end restarts the frame at position zero.
  a_frame_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_data_i.frame_end_in) |=> (pos_q == '0))
    else $error("pixel position not cleared after frame end");

  // The blended sum cannot exceed four times the largest history entry.
  a_sum_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.luma_out <= LUMA_W'(252)))
    else $error("blended luma out of range");

  // A word only reaches the output from the last stage.
  a_out_from_s3 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !s3_vld_q) |=> !out_vld_q)
    else $error("output word without a source");

endmodule

// ----- design/tlfb_row_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfb_row_ram
// Simple dual-port row memory with a registered read port.
// ----------------------------------------------------------------------------
module tlfb_row_ram #(
  parameter int unsigned DEPTH  = 16384,
  parameter int unsigned ADDR_W = 14,
  parameter int unsigned DATA_W = 192
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
